// ===== rtl/core/rbfcwg_pkg.sv =====
// ----------------------------------------------------------------------------
// rbfcwg_pkg
// Shared types, codes and helpers of the RBF center/width gradient block.
// ----------------------------------------------------------------------------
package rbfcwg_pkg;

  // default number of input dimensions
  localparam int MAX_DIMS_DEF = 8;
  // dimension field is 3 bits, so at most this many entries are addressable
  localparam int DIM_SPAN     = 8;

  // request codes
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_PATTERN = 2'd1;
  localparam logic [1:0] REQ_EMIT    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_WEIGHT  = 3'd0;
  localparam logic [2:0] CFG_GAIN    = 3'd1;
  localparam logic [2:0] CFG_DIVISOR = 3'd2;
  localparam logic [2:0] CFG_OFFSET  = 3'd3;
  localparam logic [2:0] CFG_SLOPE   = 3'd4;
  localparam logic [2:0] CFG_DIMS    = 3'd5;

  // configuration reset values
  localparam logic [31:0] WEIGHT_RST  = 32'h0001_0000;
  localparam logic [30:0] DIVISOR_RST = 31'h0001_0000;
  localparam logic [3:0]  DIMS_RST    = 4'd8;

  // width gradient divides by one Q16.16 unit
  localparam logic [31:0] WIDTH_SCALE = 32'h0001_0000;

  // dividend width of the emit division and its last step
  localparam int          DVD_W    = 96;
  localparam logic [6:0]  DIV_LAST = 7'(DVD_W - 1);

  // shared multiplier operand selection
  typedef enum logic [3:0] {
    MUL_NONE       = 4'd0,
    MUL_DIFF_DX    = 4'd1,
    MUL_T_H        = 4'd2,
    MUL_GAIN_INP   = 4'd3,
    MUL_G_SLOPE    = 4'd4,
    MUL_DIFF_INNER = 4'd5,
    MUL_U_H        = 4'd6,
    MUL_MAG_LO     = 4'd7,
    MUL_MAG_HI     = 4'd8
  } mul_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     do_load;      // store center coordinate, clear its accumulator (dim 0: width too)
    logic     pat_start;    // latch pattern operands
    logic     emit_start;   // reset emit walk
    mul_sel_t mul_sel;
    logic     acc_coord;    // add coordinate term
    logic     inner_latch;  // register inner width value
    logic     acc_width;    // add width term
    logic     em_load;      // latch magnitudes of current result
    logic     em_p0;        // keep low partial product
    logic     sum_init;     // form dividend, start division
    logic     div_step;     // one quotient bit
    logic     out_load;     // write output register
    logic     next_item;    // advance emit walk
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic dim_ok;     // incoming dimension is in range
    logic dim_zero;   // latched pattern is on dimension 0
    logic k_last;     // last coordinate result of the walk
    logic is_width;   // walk is on the width result
    logic div_last;   // division on its final step
    logic out_free;   // output register can take a result
  } sts_t;

  // clamp a signed 64-bit value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor shift by 16 of a product, then clamp
  function automatic logic [31:0] sat_shr16(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v >>> 16;
    return sat32(s);
  endfunction

  // 64-bit add clamped at the signed range
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    logic [63:0] r;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rbfcwg_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbfcwg_ctrl
// Sequencer: steps the shared multiplier, accumulators and emit divider.
// ----------------------------------------------------------------------------
module rbfcwg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  rbfcwg_pkg::sts_t  sts,
  output rbfcwg_pkg::cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_P1    = 16'h0002,
    S_P2    = 16'h0004,
    S_P3    = 16'h0008,
    S_W1    = 16'h0010,
    S_W2    = 16'h0020,
    S_W3    = 16'h0040,
    S_W4    = 16'h0080,
    S_W5    = 16'h0100,
    S_W6    = 16'h0200,
    S_E_LD  = 16'h0400,
    S_E_M0  = 16'h0800,
    S_E_M1  = 16'h1000,
    S_E_SUM = 16'h2000,
    S_E_DIV = 16'h4000,
    S_E_PUT = 16'h8000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = rbfcwg_pkg::MUL_NONE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            rbfcwg_pkg::REQ_LOAD: begin
              cmd.do_load = sts.dim_ok;
            end
            rbfcwg_pkg::REQ_PATTERN: begin
              cmd.pat_start = 1'b1;
              if (sts.dim_ok) state_next = S_P1;
            end
            rbfcwg_pkg::REQ_EMIT: begin
              cmd.emit_start = 1'b1;
              state_next     = S_E_LD;
            end
            default: ;
          endcase
        end
      end
      S_P1: begin
        cmd.mul_sel = rbfcwg_pkg::MUL_DIFF_DX;
        state_next  = S_P2;
      end
      S_P2: begin
        cmd.mul_sel = rbfcwg_pkg::MUL_T_H;
        state_next  = S_P3;
      end
      S_P3: begin
        cmd.acc_coord = 1'b1;
        state_next    = sts.dim_zero ? S_W1 : S_IDLE;
      end
      S_W1: begin
        cmd.mul_sel = rbfcwg_pkg::MUL_GAIN_INP;
        state_next  = S_W2;
      end
      S_W2: begin
        cmd.mul_sel = rbfcwg_pkg::MUL_G_SLOPE;
        state_next  = S_W3;
      end
      S_W3: begin
        cmd.inner_latch = 1'b1;
        state_next      = S_W4;
      end
      S_W4: begin
        cmd.mul_sel = rbfcwg_pkg::MUL_DIFF_INNER;
        state_next  = S_W5;
      end
      S_W5: begin
        cmd.mul_sel = rbfcwg_pkg::MUL_U_H;
        state_next  = S_W6;
      end
      S_W6: begin
        cmd.acc_width = 1'b1;
        state_next    = S_IDLE;
      end
      S_E_LD: begin
        cmd.em_load = 1'b1;
        state_next  = S_E_M0;
      end
      S_E_M0: begin
        cmd.mul_sel = rbfcwg_pkg::MUL_MAG_LO;
        state_next  = S_E_M1;
      end
      S_E_M1: begin
        cmd.em_p0   = 1'b1;
        cmd.mul_sel = rbfcwg_pkg::MUL_MAG_HI;
        state_next  = S_E_SUM;
      end
      S_E_SUM: begin
        // width result is a plain shift, no division needed
        cmd.sum_init = 1'b1;
        state_next   = sts.is_width ? S_E_PUT : S_E_DIV;
      end
      S_E_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_E_PUT;
      end
      S_E_PUT: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.next_item = 1'b1;
          state_next    = sts.is_width ? S_IDLE : S_E_LD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/rbfcwg_dp.sv =====
// ----------------------------------------------------------------------------
// rbfcwg_dp
// Datapath: config, center store, accumulators, shared multiplier, divider.
// ----------------------------------------------------------------------------
module rbfcwg_dp #(
  parameter int MAX_DIMS = rbfcwg_pkg::MAX_DIMS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [2:0]        dim_index,
  input  logic [31:0]       coord_value,
  input  logic [31:0]       upper_err,
  input  logic [31:0]       lower_err,
  input  logic [31:0]       activation,
  input  logic [31:0]       inp_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              result_kind,
  output logic [2:0]        dim_out,
  output logic [31:0]       grad_value,
  output logic              last_result,
  input  rbfcwg_pkg::cmd_t  cmd,
  output rbfcwg_pkg::sts_t  sts
);

  // addressable entries and index width
  localparam int ND = (MAX_DIMS < rbfcwg_pkg::DIM_SPAN) ? MAX_DIMS : rbfcwg_pkg::DIM_SPAN;
  localparam int IW = (ND > 1) ? $clog2(ND) : 1;

  // configuration
  logic [31:0] weight, gain, offset, slope;
  logic [30:0] divisor;
  logic [3:0]  dims;

  // state
  logic [31:0] coords [ND];
  logic [63:0] accs   [ND];
  logic [63:0] wacc;

  // pattern operands
  logic [2:0]  dim_r;
  logic [31:0] diff_r, dx_r, h_r, inp_r, inner_r;
  logic [63:0] prod;

  // emit walk
  logic [3:0]  n_r, k;
  logic        is_width, neg_r;
  logic [31:0] mw_r;
  logic [63:0] ma_r, p0_r;
  logic [95:0] dvd;
  logic [31:0] rem, dsr;
  logic [6:0]  cnt;

  logic             dim_ok;
  logic [IW-1:0]    didx, pidx, kidx;
  logic [32:0]      diff_w, dx_w, inner_w;
  logic [31:0]      prod_sat, mu;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [63:0]      term, src;
  logic [3:0]       n_w;
  logic [95:0]      sum;
  logic [32:0]      r2;
  logic             ge;
  logic             big;
  logic [31:0]      sat_q;

  assign dim_ok = (32'(dim_index) < 32'(MAX_DIMS));
  assign didx   = IW'(dim_index);
  assign pidx   = IW'(dim_r);
  assign kidx   = IW'(k);
  assign mu     = coords[didx];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      weight  <= rbfcwg_pkg::WEIGHT_RST;
      gain    <= '0;
      divisor <= rbfcwg_pkg::DIVISOR_RST;
      offset  <= '0;
      slope   <= '0;
      dims    <= rbfcwg_pkg::DIMS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rbfcwg_pkg::CFG_WEIGHT:  weight  <= cfg_data;
        rbfcwg_pkg::CFG_GAIN:    gain    <= cfg_data;
        rbfcwg_pkg::CFG_DIVISOR: divisor <= cfg_data[30:0];
        rbfcwg_pkg::CFG_OFFSET:  offset  <= cfg_data;
        rbfcwg_pkg::CFG_SLOPE:   slope   <= cfg_data;
        rbfcwg_pkg::CFG_DIMS:    dims    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // center coordinates, no reset
  always_ff @(posedge clk) begin
    if (cmd.do_load) coords[didx] <= coord_value;
  end

  // saturated differences at accept
  assign diff_w = {upper_err[31], upper_err} - {lower_err[31], lower_err};
  assign dx_w   = {coord_value[31], coord_value} - {mu[31], mu};

  always_ff @(posedge clk) begin
    if (cmd.pat_start) begin
      dim_r  <= dim_index;
      diff_r <= rbfcwg_pkg::sat32(64'(signed'(diff_w)));
      dx_r   <= rbfcwg_pkg::sat32(64'(signed'(dx_w)));
      h_r    <= activation;
      inp_r  <= inp_value;
    end
  end

  // shared multiplier with registered product
  assign prod_sat = rbfcwg_pkg::sat_shr16(prod);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      rbfcwg_pkg::MUL_DIFF_DX: begin
        mul_a = signed'({diff_r[31], diff_r});
        mul_b = signed'({dx_r[31], dx_r});
      end
      rbfcwg_pkg::MUL_T_H, rbfcwg_pkg::MUL_U_H: begin
        mul_a = signed'({prod_sat[31], prod_sat});
        mul_b = signed'({h_r[31], h_r});
      end
      rbfcwg_pkg::MUL_GAIN_INP: begin
        mul_a = signed'({gain[31], gain});
        mul_b = signed'({inp_r[31], inp_r});
      end
      rbfcwg_pkg::MUL_G_SLOPE: begin
        mul_a = signed'({prod_sat[31], prod_sat});
        mul_b = signed'({slope[31], slope});
      end
      rbfcwg_pkg::MUL_DIFF_INNER: begin
        mul_a = signed'({diff_r[31], diff_r});
        mul_b = signed'({inner_r[31], inner_r});
      end
      rbfcwg_pkg::MUL_MAG_LO: begin
        mul_a = signed'({1'b0, ma_r[31:0]});
        mul_b = signed'({1'b0, mw_r});
      end
      rbfcwg_pkg::MUL_MAG_HI: begin
        mul_a = signed'({1'b0, ma_r[63:32]});
        mul_b = signed'({1'b0, mw_r});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_p[63:0];
  end

  // inner width value: offset plus scaled slope term
  assign inner_w = {offset[31], offset} + {prod_sat[31], prod_sat};

  always_ff @(posedge clk) begin
    if (cmd.inner_latch) inner_r <= rbfcwg_pkg::sat32(64'(signed'(inner_w)));
  end

  // accumulator term: floor shift of the product
  assign term = 64'(signed'(prod) >>> 16);

  // accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ND; i++) accs[i] <= '0;
      wacc <= '0;
    end else begin
      if (cmd.do_load) begin
        accs[didx] <= '0;
        if (dim_index == 3'd0) wacc <= '0;
      end
      if (cmd.acc_coord) accs[pidx] <= rbfcwg_pkg::sat_add64(accs[pidx], term);
      if (cmd.acc_width) wacc <= rbfcwg_pkg::sat_add64(wacc, term);
    end
  end

  // emit walk: clamped count and current index
  always_comb begin
    if (dims == 4'd0) begin
      n_w = 4'd1;
    end else if (32'(dims) > 32'(MAX_DIMS)) begin
      n_w = 4'(MAX_DIMS);
    end else begin
      n_w = dims;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      n_r      <= n_w;
      k        <= '0;
      is_width <= 1'b0;
    end else if (cmd.next_item && !is_width) begin
      if (k == n_r - 4'd1) begin
        is_width <= 1'b1;
      end else begin
        k <= k + 4'd1;
      end
    end
  end

  // magnitudes and sign of the current result
  always_comb begin
    if (is_width) begin
      src = wacc;
    end else if (32'(k) < 32'(ND)) begin
      src = accs[kidx];
    end else begin
      src = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.em_load) begin
      mw_r  <= weight[31] ? (32'd0 - weight) : weight;
      ma_r  <= src[63] ? (64'd0 - src) : src;
      neg_r <= weight[31] ^ src[63];
    end
    if (cmd.em_p0) p0_r <= prod;
  end

  // exact product, doubled for coordinate results
  assign sum = {prod, 32'd0} + {32'd0, p0_r};

  // restoring division, one quotient bit a cycle; the width result
  // divides by one Q16.16 unit, which is a shift of the magnitude
  assign r2 = {rem, dvd[95]};
  assign ge = (r2 >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (cmd.sum_init) begin
      dvd <= is_width ? {16'd0, sum[95:16]} : {sum[94:0], 1'b0};
      dsr <= (divisor == '0) ? 32'd1 : {1'b0, divisor};
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? 32'(r2 - {1'b0, dsr}) : r2[31:0];
      dvd <= {dvd[94:0], ge};
      cnt <= cnt + 7'd1;
    end
  end

  // saturate quotient to signed 32 bits
  assign big = |dvd[95:32];
  always_comb begin
    if (neg_r) begin
      sat_q = (big || dvd[31]) ? 32'h8000_0000 : (32'd0 - dvd[31:0]);
    end else begin
      sat_q = (big || dvd[31]) ? 32'h7FFF_FFFF : dvd[31:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_kind <= is_width;
      dim_out     <= is_width ? 3'd0 : k[2:0];
      grad_value  <= sat_q;
      last_result <= is_width;
    end
  end

  // status
  always_comb begin
    sts          = '0;
    sts.dim_ok   = dim_ok;
    sts.dim_zero = (dim_r == 3'd0);
    sts.k_last   = (k == n_r - 4'd1);
    sts.is_width = is_width;
    sts.div_last = (cnt == rbfcwg_pkg::DIV_LAST);
    sts.out_free = !out_valid || !out_stall;
  end

endmodule

// ===== rtl/core/rbf_center_width_gradient_top.sv =====
// ----------------------------------------------------------------------------
// rbf_center_width_gradient_top
// Gradient of one RBF center's coordinates and width, signed Q16.16.
// ----------------------------------------------------------------------------
// Load: taken in idle. Pattern: P1-P3, plus W1-W6 on dimension 0 (one shared
// multiplier, one product per cycle). Emit: after the accept, each coordinate
// result runs load, two multiplies, sum, the bit-serial 96-bit divider and put,
// the width one skips the divider (shift only); results sit in an output register.
// Synchronous reset clears control and accumulators and sets the configuration
// to its reset values; center coordinates are undefined until loaded.
// ----------------------------------------------------------------------------
module rbf_center_width_gradient_top #(
  parameter int MAX_DIMS = rbfcwg_pkg::MAX_DIMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  dim_index,
  input  logic [31:0] coord_value,
  input  logic [31:0] upper_err,
  input  logic [31:0] lower_err,
  input  logic [31:0] activation,
  input  logic [31:0] inp_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [2:0]  dim_out,
  output logic [31:0] grad_value,
  output logic        last_result
);

  rbfcwg_pkg::cmd_t cmd;
  rbfcwg_pkg::sts_t sts;

  // sequencer
  rbfcwg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  rbfcwg_dp #(
    .MAX_DIMS (MAX_DIMS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .dim_index   (dim_index),
    .coord_value (coord_value),
    .upper_err   (upper_err),
    .lower_err   (lower_err),
    .activation  (activation),
    .inp_value   (inp_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .dim_out     (dim_out),
    .grad_value  (grad_value),
    .last_result (last_result),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ===== bench/rbf_center_width_gradient_top_tb.sv =====
// ----------------------------------------------------------------------------
// rbf_center_width_gradient_top_tb
// Self-checking bench for the RBF center/width gradient block: a behavioral
// predictor tracks the coordinate and width accumulators, every emitted
// gradient is compared against it, with random gaps, stalls and back-pressure.
// ----------------------------------------------------------------------------
module rbf_center_width_gradient_top_tb;

  localparam int  NDIMS       = 8;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  SETTLE      = 24;    // longest pattern is one on dimension 0
  localparam int  TAIL        = 1200;  // one full emit run
  localparam logic [1:0] REQ_NOP = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [2:0]  dim;
    logic [31:0] value;
    logic        last;
  } grad_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [2:0]  dim_index = '0;
  logic [31:0] coord_value = '0;
  logic [31:0] upper_err = '0;
  logic [31:0] lower_err = '0;
  logic [31:0] activation = '0;
  logic [31:0] inp_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        result_kind;
  logic [2:0]  dim_out;
  logic [31:0] grad_value;
  logic        last_result;

  rbf_center_width_gradient_top u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .dim_index(dim_index), .coord_value(coord_value),
    .upper_err(upper_err), .lower_err(lower_err), .activation(activation),
    .inp_value(inp_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .dim_out(dim_out), .grad_value(grad_value),
    .last_result(last_result)
  );

  // predictor state
  logic signed [31:0] m_weight, m_gain, m_offset, m_slope;
  logic [30:0]        m_divisor;
  logic [3:0]         m_dims;
  logic signed [31:0] m_coord [NDIMS];
  logic signed [63:0] m_acc [NDIMS];
  logic signed [63:0] m_wacc;

  grad_t grad_q[$];
  int    fail_cnt = 0;
  int    item_cnt = 0;
  int    emit_cnt = 0;
  int    grad_cnt = 0;
  int    cfg_cnt = 0;
  int    cyc = 0;

  // sender burst control
  bit    gaps_on = 1'b1;
  int    burst_left = 4;
  // receiver control
  int    stall_pct = 30;
  bit    hold_start = 1'b0;
  int    hold_cnt = 0;

  initial forever #2 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      return a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  // sat32(trunc(factor*w*acc/d)) with the product kept exact
  function automatic logic [31:0] scaled_quot(input logic signed [31:0] w,
                                              input logic signed [63:0] acc,
                                              input bit dbl, input logic [30:0] d);
    logic signed [127:0] a, b, p, dd, q;
    a = w;
    b = acc;
    p = a * b;
    if (dbl) p = p * 2;
    dd = d;
    if (d == 0) dd = 1;
    q = p / dd;
    if (q > 128'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -128'sd2147483648) return 32'h8000_0000;
    return q[31:0];
  endfunction

  task automatic model_item(input logic [1:0] rt, input logic [2:0] dm,
                            input logic signed [31:0] x, ue, le, h, inp);
    logic signed [63:0] diff, dx, t, g, inner, u, a64, b64;
    int n;
    grad_t r;
    case (rt)
      rbfcwg_pkg::REQ_LOAD: begin
        m_coord[dm] = x;
        m_acc[dm] = 0;
        if (dm == 0) m_wacc = 0;
      end
      rbfcwg_pkg::REQ_PATTERN: begin
        a64 = ue; b64 = le;
        diff = clamp32(a64 - b64);
        a64 = x; b64 = m_coord[dm];
        dx = clamp32(a64 - b64);
        t = clamp32((diff * dx) >>> 16);
        a64 = h;
        m_acc[dm] = add_sat64(m_acc[dm], (t * a64) >>> 16);
        if (dm == 0) begin
          a64 = m_gain; b64 = inp;
          g = clamp32((a64 * b64) >>> 16);
          b64 = m_slope;
          a64 = m_offset;
          inner = clamp32(a64 + clamp32((g * b64) >>> 16));
          u = clamp32((diff * inner) >>> 16);
          a64 = h;
          m_wacc = add_sat64(m_wacc, (u * a64) >>> 16);
        end
      end
      rbfcwg_pkg::REQ_EMIT: begin
        n = m_dims;
        if (n == 0) n = 1;
        if (n > NDIMS) n = NDIMS;
        for (int k = 0; k < n; k++) begin
          r.kind = 1'b0; r.dim = 3'(k); r.last = 1'b0;
          r.value = scaled_quot(m_weight, m_acc[k], 1'b1, m_divisor);
          grad_q.push_back(r);
        end
        r.kind = 1'b1; r.dim = 3'd0; r.last = 1'b1;
        r.value = scaled_quot(m_weight, m_wacc, 1'b0, rbfcwg_pkg::WIDTH_SCALE[30:0]);
        grad_q.push_back(r);
        emit_cnt++;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rbfcwg_pkg::CFG_WEIGHT:  m_weight = val;
      rbfcwg_pkg::CFG_GAIN:    m_gain = val;
      rbfcwg_pkg::CFG_DIVISOR: m_divisor = val[30:0];
      rbfcwg_pkg::CFG_OFFSET:  m_offset = val;
      rbfcwg_pkg::CFG_SLOPE:   m_slope = val;
      rbfcwg_pkg::CFG_DIMS:    m_dims = val[3:0];
      default: ;
    endcase
    cfg_cnt++;
  endtask

  task automatic send_item(input logic [1:0] rt, input logic [2:0] dm,
                           input logic [31:0] x, ue, le, h, inp);
    in_valid <= 1'b1;
    req_type <= rt; dim_index <= dm; coord_value <= x;
    upper_err <= ue; lower_err <= le; activation <= h; inp_value <= inp;
    do @(posedge clk); while (in_stall);
    model_item(rt, dm, x, ue, le, h, inp);
    item_cnt++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 20);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // wait for every expected result, then let a no-result item finish
  task automatic drain();
    in_valid <= 1'b0;
    while (grad_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h0003_FFFF);
      4: return -$urandom_range(0, 32'h0003_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic load_center();
    for (int k = 0; k < NDIMS; k++)
      send_item(rbfcwg_pkg::REQ_LOAD, 3'(k), rnd32(), rnd32(), rnd32(), rnd32(), rnd32());
  endtask

  task automatic send_pattern(input logic [2:0] dm);
    send_item(rbfcwg_pkg::REQ_PATTERN, dm, rnd32(), rnd32(), rnd32(), rnd32(), rnd32());
  endtask

  task automatic random_config();
    drain();
    write_reg(rbfcwg_pkg::CFG_WEIGHT, rnd32());
    write_reg(rbfcwg_pkg::CFG_GAIN, rnd32());
    case ($urandom_range(0, 4))
      0: write_reg(rbfcwg_pkg::CFG_DIVISOR, 32'h1);
      1: write_reg(rbfcwg_pkg::CFG_DIVISOR, 32'h7FFF_FFFF);
      2: write_reg(rbfcwg_pkg::CFG_DIVISOR, 32'h0);
      default: write_reg(rbfcwg_pkg::CFG_DIVISOR, $urandom);
    endcase
    write_reg(rbfcwg_pkg::CFG_OFFSET, rnd32());
    write_reg(rbfcwg_pkg::CFG_SLOPE, rnd32());
    write_reg(rbfcwg_pkg::CFG_DIMS, 32'($urandom_range(0, 15)));
  endtask

  // ---------------------------------------------------------------- tests
  // emit straight out of reset: defaults and cleared accumulators
  task automatic test_reset_state();
    send_item(rbfcwg_pkg::REQ_EMIT, 3'd0, '0, '0, '0, '0, '0);
    drain();
  endtask

  // field extremes, ignored request type, every request
  task automatic test_directed();
    write_reg(rbfcwg_pkg::CFG_GAIN, 32'h0002_0000);
    write_reg(rbfcwg_pkg::CFG_OFFSET, 32'h0000_8000);
    write_reg(rbfcwg_pkg::CFG_SLOPE, 32'hFFFF_0000);
    send_item(rbfcwg_pkg::REQ_LOAD, 3'd0, 32'h8000_0000, '0, '0, '0, '0);
    send_item(rbfcwg_pkg::REQ_LOAD, 3'd1, 32'h7FFF_FFFF, '0, '0, '0, '0);
    for (int k = 2; k < NDIMS; k++)
      send_item(rbfcwg_pkg::REQ_LOAD, 3'(k), 32'(k) << 16, '0, '0, '0, '0);
    send_item(rbfcwg_pkg::REQ_PATTERN, 3'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(rbfcwg_pkg::REQ_PATTERN, 3'd1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000);
    send_item(rbfcwg_pkg::REQ_PATTERN, 3'd7, 32'h0003_0000, 32'h0001_0000, 32'h0,
              32'h0000_8000, 32'h0001_0000);
    send_item(REQ_NOP, 3'd7, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_item(rbfcwg_pkg::REQ_PATTERN, 3'd0, 32'h0, 32'h0000_4000, 32'hFFFF_C000,
              32'hFFFF_0000, 32'hFFFF_FFFF);
    send_item(rbfcwg_pkg::REQ_EMIT, 3'd5, $urandom, '0, '0, '0, '0);
    drain();
    // weight and divisor at their extremes, dims of 1, 0 and 15
    write_reg(rbfcwg_pkg::CFG_WEIGHT, 32'h7FFF_FFFF);
    write_reg(rbfcwg_pkg::CFG_DIVISOR, 32'h1);
    write_reg(rbfcwg_pkg::CFG_DIMS, 32'd1);
    send_item(rbfcwg_pkg::REQ_EMIT, 3'd0, '0, '0, '0, '0, '0);
    drain();
    write_reg(rbfcwg_pkg::CFG_WEIGHT, 32'h8000_0000);
    write_reg(rbfcwg_pkg::CFG_DIVISOR, 32'h7FFF_FFFF);
    write_reg(rbfcwg_pkg::CFG_DIMS, 32'd0);
    write_reg(rbfcwg_pkg::CFG_WEIGHT, 32'h8000_0000);
    send_item(rbfcwg_pkg::REQ_EMIT, 3'd0, '0, '0, '0, '0, '0);
    drain();
    write_reg(rbfcwg_pkg::CFG_DIMS, 32'd15);
    write_reg(rbfcwg_pkg::CFG_DIVISOR, 32'h0);
    send_item(rbfcwg_pkg::REQ_EMIT, 3'd0, '0, '0, '0, '0, '0);
    drain();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_start = 1'b1;
    gaps_on = 1'b0;
    for (int j = 0; j < 3; j++) begin
      repeat (6) send_pattern(3'($urandom_range(0, 7)));
      send_item(rbfcwg_pkg::REQ_EMIT, 3'd0, '0, '0, '0, '0, '0);
    end
    gaps_on = 1'b1;
    drain();
  endtask

  // well-formed center runs, plus noise and broken runs
  task automatic test_random(input int target);
    while (item_cnt < target) begin
      if ($urandom_range(0, 3) == 0) random_config();
      if ($urandom_range(0, 9) < 8) load_center();
      else send_item(rbfcwg_pkg::REQ_LOAD, 3'($urandom_range(0, 7)), rnd32(), rnd32(),
                     rnd32(), rnd32(), rnd32());
      repeat ($urandom_range(3, 16)) begin
        if ($urandom_range(0, 9) == 0)
          send_item(REQ_NOP, 3'($urandom), $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        else
          send_pattern($urandom_range(0, 3) == 0 ? 3'd0 : 3'($urandom_range(0, 7)));
      end
      send_item(rbfcwg_pkg::REQ_EMIT, 3'($urandom), $urandom, $urandom, $urandom,
                $urandom, $urandom);
      if ($urandom_range(0, 4) == 0)
        send_item(rbfcwg_pkg::REQ_EMIT, 3'd0, '0, '0, '0, '0, '0);
    end
    drain();
  endtask

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_start || hold_cnt > 0) begin
      if (hold_start) begin
        hold_cnt = 3000;
        hold_start = 1'b0;
      end
      hold_cnt = hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      case ((cyc / 700) % 3)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < stall_pct);
        default: out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    grad_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (grad_q.size() == 0) begin
        $error("unexpected result transaction: kind %0d dim %0d value %h",
               result_kind, dim_out, grad_value);
        fail_cnt++;
      end else begin
        exp_r = grad_q.pop_front();
        grad_cnt++;
        if (result_kind !== exp_r.kind) begin
          $error("result_kind: expected %0d actual %0d", exp_r.kind, result_kind);
          fail_cnt++;
        end
        if (dim_out !== exp_r.dim) begin
          $error("dim_out: expected %0d actual %0d", exp_r.dim, dim_out);
          fail_cnt++;
        end
        if (grad_value !== exp_r.value) begin
          $error("grad_value: expected %h actual %h", exp_r.value, grad_value);
          fail_cnt++;
        end
        if (last_result !== exp_r.last) begin
          $error("last_result: expected %0d actual %0d", exp_r.last, last_result);
          fail_cnt++;
        end
      end
    end
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    m_weight = rbfcwg_pkg::WEIGHT_RST; m_gain = 0; m_offset = 0; m_slope = 0;
    m_divisor = rbfcwg_pkg::DIVISOR_RST; m_dims = rbfcwg_pkg::DIMS_RST; m_wacc = 0;
    for (int k = 0; k < NDIMS; k++) begin
      m_coord[k] = 0;
      m_acc[k] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_backpressure();
    test_random(420);
    in_valid <= 1'b0;
    repeat (TAIL) @(posedge clk);
    if (grad_q.size() != 0) begin
      $error("%0d expected results never arrived", grad_q.size());
      fail_cnt++;
    end
    $display("covered %0d transactions, %0d emits, %0d gradients checked, %0d reg writes",
             item_cnt, emit_cnt, grad_cnt, cfg_cnt);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rbfcwg_pkg.sv
rtl/core/rbfcwg_ctrl.sv
rtl/core/rbfcwg_dp.sv
rtl/core/rbf_center_width_gradient_top.sv
bench/rbf_center_width_gradient_top_tb.sv
